// File: rtl/core/max_three_window_sum_assert.svh
// Assertion macros used by the checker of the three-window sum block.
`ifndef MAX_THREE_WINDOW_SUM_ASSERT_SVH
`define MAX_THREE_WINDOW_SUM_ASSERT_SVH

// Implication that is switched off while reset is high.
`define MTWS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("max_three_window_sum assertion failed");

// Next-cycle implication that is also checked during reset.
`define MTWS_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("max_three_window_sum assertion failed");

`endif

// File: rtl/core/mtws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtws_pkg
// Shared widths and types of the three-window sum block.
// ----------------------------------------------------------------------------
package mtws_pkg;

  localparam int SAMPLE_W = 8;
  localparam int SUM_W    = 18;
  localparam int TWO_W    = 19;
  localparam int OUT_W    = 20;
  localparam int LEN_W    = 11;

  // One word of the ring memory: the sample and the one- and two-window
  // bests stored for the same position.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SUM_W-1:0]    one_best;
    logic [TWO_W-1:0]    two_best;
  } ring_word_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } upd_ctrl_t;

endpackage

// File: rtl/core/mtws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtws_if
// Valid/ready channels for items in and results out.
// ----------------------------------------------------------------------------
interface mtws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] item_value;
  logic       first_item;

  modport source (output valid, output item_value, output first_item, input ready);
  modport sink (input valid, input item_value, input first_item, output ready);
endinterface

interface mtws_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] best_three;
  logic        answer_ready;

  modport source (output valid, output best_three, output answer_ready, input ready);
  modport sink (input valid, input best_three, input answer_ready, output ready);
endinterface

// File: rtl/core/mtws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtws_ram
// Simple dual-port synchronous RAM, registered read, read-first.
// ----------------------------------------------------------------------------
module mtws_ram #(
  parameter int W     = 45,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/mtws_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtws_update
// Running window sum and the one-, two- and three-window bests.
// ----------------------------------------------------------------------------
module mtws_update import mtws_pkg::*; #(
  parameter int CW = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  upd_ctrl_t           ctrl,
  input  logic [LEN_W-1:0]    k,
  input  logic [SAMPLE_W-1:0] x,
  input  logic                first,
  input  ring_word_t          rd,
  output ring_word_t          wr,
  output logic [OUT_W-1:0]    best_three,
  output logic                answer_ready
);

  logic [SUM_W-1:0] window_sum, best_one;
  logic [TWO_W-1:0] best_two;
  logic [OUT_W-1:0] best_three_reg;
  logic [CW-1:0]    item_count;

  logic [SUM_W-1:0] ws, b1, sum, sub, d1;
  logic [TWO_W-1:0] b2, c2, d2;
  logic [OUT_W-1:0] b3, c3, d3;
  logic [CW-1:0]    cnt, n, k1, k2, k3, count_next;

  always_comb begin
    k1  = CW'(k);
    k2  = k1 << 1;
    k3  = k2 + k1;
    // A first item starts from an empty set.
    cnt = first ? '0 : item_count;
    ws  = first ? '0 : window_sum;
    b1  = first ? '0 : best_one;
    b2  = first ? '0 : best_two;
    b3  = first ? '0 : best_three_reg;

    sub = (cnt >= k1) ? SUM_W'(rd.sample) : '0;
    sum = ws + SUM_W'(x) - sub;
    n   = cnt + CW'(1);

    d1 = (n >= k1 && sum > b1) ? sum : b1;
    c2 = TWO_W'(rd.one_best) + TWO_W'(sum);
    d2 = (n >= k2 && c2 > b2) ? c2 : b2;
    c3 = OUT_W'(rd.two_best) + OUT_W'(sum);
    d3 = (n >= k3 && c3 > b3) ? c3 : b3;

    count_next   = (n > k3) ? k3 : n;
    wr.sample    = x;
    wr.one_best  = d1;
    wr.two_best  = d2;
    best_three   = d3;
    answer_ready = (count_next >= k3);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      window_sum     <= '0;
      best_one       <= '0;
      best_two       <= '0;
      best_three_reg <= '0;
      item_count     <= '0;
    end else if (ctrl.advance) begin
      window_sum     <= sum;
      best_one       <= d1;
      best_two       <= d2;
      best_three_reg <= d3;
      item_count     <= count_next;
    end
  end

endmodule

// File: rtl/core/max_three_window_sum.sv
`timescale 1ns / 1ps
// An item is registered in the update stage, then its result in the output
// register. Throughput: one item per cycle unless results stall, set by a
// ring read and write per cycle; a read of a same-cycle write is forwarded.
// Reset clears control state and the running sums, sets window_len to 1 and
// leaves the ring memory contents as they are.
// ----------------------------------------------------------------------------
// max_three_window_sum
// Streaming best total of three disjoint windows over a stream of items.
// ----------------------------------------------------------------------------
module max_three_window_sum import mtws_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  mtws_in_if.sink          items,
  mtws_out_if.source       results
);

  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KMAX = (MAX_WINDOW < 2047) ? MAX_WINDOW : 2047;
  localparam int CW   = $clog2(3 * KMAX + 2);
  localparam int ZW   = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int RW   = $bits(ring_word_t);

  logic [LEN_W-1:0] window_len;
  logic [LEN_W-1:0] k;
  logic [AW-1:0]    ptr, p_eff;
  logic [ZW-1:0]    p_inc;

  logic                b_valid, b_first;
  logic [SAMPLE_W-1:0] b_x;
  logic [AW-1:0]       b_addr;
  logic                byp_hit;
  ring_word_t          byp_data;

  logic             out_valid, out_answer;
  logic [OUT_W-1:0] out_best;

  logic        accept, b_advance;
  logic [RW-1:0] ram_rdata;
  ring_word_t  rd_word, wr_word;
  upd_ctrl_t   ctrl;
  logic [OUT_W-1:0] best_three_new;
  logic        answer_new;

  always_comb begin
    if (window_len == '0) begin
      k = LEN_W'(1);
    end else if (32'(window_len) > MAX_WINDOW) begin
      k = LEN_W'(KMAX);
    end else begin
      k = window_len;
    end
  end

  assign b_advance     = b_valid && (!out_valid || results.ready);
  assign items.ready   = !b_valid || b_advance;
  assign accept        = items.valid && items.ready;

  always_comb begin
    if (items.first_item || ZW'(ptr) >= ZW'(k)) begin
      p_eff = '0;
    end else begin
      p_eff = ptr;
    end
    p_inc = ZW'(p_eff) + ZW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_W'(1);
    end else if (cfg_wr_en) begin
      window_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      ptr <= '0;
    end else if (accept) begin
      ptr <= (p_inc >= ZW'(k)) ? '0 : AW'(p_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_advance) begin
      b_valid <= 1'b0;
    end
  end

  // The write of the item leaving the update stage lands in the same cycle
  // as the read for the next one; a matching address takes the new word.
  always_ff @(posedge clk) begin
    if (accept) begin
      b_x      <= items.item_value;
      b_first  <= items.first_item;
      b_addr   <= p_eff;
      byp_hit  <= b_advance && (b_addr == p_eff);
      byp_data <= wr_word;
    end
  end

  mtws_ram #(
    .W     (RW),
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (p_eff),
    .rd_data (ram_rdata),
    .wr_en   (b_advance),
    .wr_addr (b_addr),
    .wr_data (wr_word)
  );

  assign rd_word      = byp_hit ? byp_data : ring_word_t'(ram_rdata);
  assign ctrl.advance = b_advance;
  assign ctrl.clear   = cfg_wr_en;

  mtws_update #(
    .CW (CW)
  ) u_update (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .k            (k),
    .x            (b_x),
    .first        (b_first),
    .rd           (rd_word),
    .wr           (wr_word),
    .best_three   (best_three_new),
    .answer_ready (answer_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_advance) begin
      out_best   <= best_three_new;
      out_answer <= answer_new;
    end
  end

  assign results.valid        = out_valid;
  assign results.best_three   = out_best;
  assign results.answer_ready = out_answer;

endmodule

// File: rtl/core/mtws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtws_checker
// Port-level checks of the three-window sum block, bound to the top level.
// ----------------------------------------------------------------------------
`include "max_three_window_sum_assert.svh"

module mtws_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [19:0] best_three,
  input logic        answer_ready
);

  // A stalled result keeps its transfer pending with the same payload.
  `MTWS_ASSERT_IMP(a_out_hold, clk, rst, out_valid && !out_ready, ##1 (out_valid && $stable(best_three) && $stable(answer_ready)))

  // No answer means no total yet.
  `MTWS_ASSERT_IMP(a_no_answer_zero, clk, rst, out_valid && !answer_ready, best_three == 20'd0)

  // A result that newly appears traces back to an item transfer, through the update stage and the output register.
  `MTWS_ASSERT_IMP(a_result_source, clk, rst, $rose(out_valid), $past(in_valid && in_ready, 2))

  // Reset empties the pipeline.
  `MTWS_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid)

endmodule

bind max_three_window_sum mtws_checker u_mtws_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (items.valid),
  .in_ready     (items.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .best_three   (results.best_three),
  .answer_ready (results.answer_ready)
);

// File: tb/sv/max_three_window_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_three_window_sum_checker
// Watches the item and result channels and the window length port of the
// three-window sum block. It keeps its own copy of the running sums and the
// delay rings, works out the expected result for every item transfer, and
// compares each result transfer with the oldest expectation.
// ----------------------------------------------------------------------------
module max_three_window_sum_checker import mtws_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  mtws_in_if               items,
  mtws_out_if              results,
  output int               fail_count,
  output int               pending,
  output int               results_checked,
  output int               full_answers,
  output int               top_total
);

  typedef struct packed {
    logic [OUT_W-1:0] best_three;
    logic             answer_ready;
  } window_result_t;

  logic [SAMPLE_W-1:0] sample_mem [MAX_WINDOW];
  logic [SUM_W-1:0]    one_mem    [MAX_WINDOW];
  logic [TWO_W-1:0]    two_mem    [MAX_WINDOW];

  logic [LEN_W-1:0] len_reg;
  logic [SUM_W-1:0] run_sum;
  logic [SUM_W-1:0] top_one;
  logic [TWO_W-1:0] top_two;
  logic [OUT_W-1:0] top_three;
  int unsigned      slot;
  int unsigned      seen;

  window_result_t expected_totals [$];

  function automatic int unsigned window_span();
    if (len_reg == '0) return 1;
    if (len_reg > MAX_WINDOW) return MAX_WINDOW;
    return len_reg;
  endfunction

  function automatic void restart_set();
    run_sum   = '0;
    top_one   = '0;
    top_two   = '0;
    top_three = '0;
    slot      = 0;
    seen      = 0;
  endfunction

  // Folds one item into the running state and queues the total it yields.
  function automatic void fold_item(input logic [SAMPLE_W-1:0] value,
                                    input logic restart);
    int unsigned      k;
    int unsigned      p;
    int unsigned      n;
    int unsigned      acc;
    logic [SUM_W-1:0] win;
    logic [TWO_W-1:0] pair;
    logic [OUT_W-1:0] triple;
    window_result_t   res;
    k = window_span();
    if (restart) restart_set();
    if (slot >= k) slot = 0;
    p = slot;
    acc = run_sum + value;
    if (seen >= k) acc = acc - sample_mem[p];
    win = acc[SUM_W-1:0];
    n = seen + 1;
    if (n >= k && win > top_one) top_one = win;
    if (n >= 2 * k) begin
      pair = one_mem[p] + win;
      if (pair > top_two) top_two = pair;
    end
    if (n >= 3 * k) begin
      triple = two_mem[p] + win;
      if (triple > top_three) top_three = triple;
    end
    sample_mem[p] = value;
    one_mem[p]    = top_one;
    two_mem[p]    = top_two;
    run_sum       = win;
    slot          = (p + 1 >= k) ? 0 : p + 1;
    seen          = (n > 3 * k) ? 3 * k : n;
    res.best_three   = top_three;
    res.answer_ready = (seen >= 3 * k);
    expected_totals.push_back(res);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_result(input logic [OUT_W-1:0] total, input logic ready_flag);
    window_result_t want;
    if (expected_totals.size() == 0) begin
      report_mismatch($sformatf("result %0d/%0b with nothing expected", total, ready_flag));
    end else begin
      want = expected_totals.pop_front();
      if (total !== want.best_three)
        report_mismatch($sformatf("best_three got %0d, expected %0d", total,
                                  want.best_three));
      if (ready_flag !== want.answer_ready)
        report_mismatch($sformatf("answer_ready got %0b, expected %0b", ready_flag,
                                  want.answer_ready));
      results_checked++;
      if (want.answer_ready) full_answers++;
      if (want.best_three > top_total) top_total = want.best_three;
    end
  endtask

  // A result can only come from an earlier transfer, so it is checked
  // before the item of the same edge is folded in.
  always @(posedge clk) begin
    if (rst) begin
      len_reg = 1;
      restart_set();
      expected_totals.delete();
    end else begin
      if (results.valid && results.ready)
        check_result(results.best_three, results.answer_ready);
      if (cfg_wr_en) begin
        len_reg = cfg_wr_data;
        restart_set();
      end
      if (items.valid && items.ready)
        fold_item(items.item_value, items.first_item);
    end
    pending <= expected_totals.size();
  end

endmodule

// File: tb/sv/tb_max_three_window_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_three_window_sum
// Drives items and window lengths into the three-window sum block with random
// gaps and stalls on both channels, including long receiver holds that back
// the block up. A checker beside the block predicts every total.
// ----------------------------------------------------------------------------
module tb_max_three_window_sum;
  import mtws_pkg::*;

  localparam int MAX_WINDOW   = 1024;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 2000000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  int fail_count;
  int pending;
  int results_checked;
  int full_answers;
  int top_total;
  int settings_used;
  int long_holds;
  int cycle_count;
  bit src_quiet;

  mtws_in_if  items_ch ();
  mtws_out_if results_ch ();

  max_three_window_sum #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .items      (items_ch),
    .results    (results_ch)
  );

  max_three_window_sum_checker #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .items          (items_ch),
    .results        (results_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .full_answers   (full_answers),
    .top_total      (top_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_max_three_window_sum failed");
      $finish;
    end
  end

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] random_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(0, 255));
    if (r < 8) return 8'hFF;
    if (r == 8) return 8'h00;
    return 8'($urandom_range(0, 3));
  endfunction

  task automatic push_item(input logic [7:0] value, input logic restart);
    int gap;
    gap = src_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid      <= 1'b1;
    items_ch.item_value <= value;
    items_ch.first_item <= restart;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
  endtask

  // Waits until every expected total has been seen, then lets the pipe settle.
  task automatic drain();
    items_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [LEN_W-1:0] len);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random_set(input logic [LEN_W-1:0] len);
    int span;
    int count;
    span  = (len == 0) ? 1 : ((len > MAX_WINDOW) ? MAX_WINDOW : len);
    count = ((4 * span > 72) ? 4 * span : 72) + $urandom_range(0, 16);
    if (span > 256) count = 96;
    set_window(len);
    src_quiet = ($urandom_range(0, 3) == 0);
    repeat (count) push_item(random_value(), $urandom_range(0, 69) == 0);
  endtask

  // Result side: random stalls after transfers, plus a long hold every few
  // hundred results while the sender keeps offering items.
  initial begin : result_sink
    int  stall_left;
    int  hold_left;
    int  taken;
    int  next_hold;
    bit  quiet;
    stall_left = 0;
    hold_left  = 0;
    taken      = 0;
    next_hold  = 300;
    quiet      = 1'b0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (results_ch.valid && results_ch.ready) begin
        taken++;
        stall_left = quiet ? 0 : pick_gap();
      end
      if ($urandom_range(0, 249) == 0) quiet = !quiet;
      if (hold_left == 0 && taken >= next_hold) begin
        hold_left = 120;
        next_hold += 450;
        long_holds++;
      end
      if (hold_left > 0) begin
        results_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        results_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    items_ch.valid      <= 1'b0;
    items_ch.item_value <= '0;
    items_ch.first_item <= 1'b0;
    src_quiet           = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Window of one after reset; a restart on the very first item.
    push_item(8'hFF, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'h01, 1'b0);
    push_item(8'h02, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'hC8, 1'b0);

    // A length of zero behaves as a window of one.
    set_window(11'd0);
    push_item(8'h55, 1'b0);
    push_item(8'hAA, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);

    set_window(11'd2);
    repeat (6) push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);

    run_random_set(11'd3);
    run_random_set(11'd1);
    run_random_set(11'd5);
    run_random_set(11'd2);
    run_random_set(11'd0);
    run_random_set(11'd8);
    run_random_set(11'd13);
    run_random_set(11'd4);
    run_random_set(11'd1);
    run_random_set(11'd31);
    run_random_set(11'd64);
    run_random_set(LEN_W'($urandom_range(1, 40)));
    run_random_set(LEN_W'($urandom_range(1, 40)));

    // A window filled with the largest value keeps every total at its peak.
    set_window(11'd40);
    src_quiet = 1'b1;
    repeat (3 * 40) push_item(8'hFF, 1'b0);
    src_quiet = 1'b0;
    repeat (32) push_item(random_value(), 1'b0);

    // A length past the ring size is clipped to it.
    run_random_set(11'd2047);
    run_random_set(11'd1);

    drain();
    $display("Checked %0d totals over %0d window settings, %0d with three windows filled.",
             results_checked, settings_used, full_answers);
    $display("Largest total seen %0d; the receiver held off long %0d times.",
             top_total, long_holds);
    if (fail_count == 0) begin
      $display("tb_max_three_window_sum passed");
    end else begin
      $display("tb_max_three_window_sum failed");
    end
    $finish;
  end

endmodule
